FILE: hw/rtl/pdh_pkg.sv
// Package for the pair-distance histogram block: field widths, arithmetic constants,
// the multiply/divide unit command types and the microcode table for that unit.
// No dependencies.
`default_nettype none
package pdh_pkg;

	localparam int COORD_W   = 24;
	localparam int NB_W      = 7;
	localparam int BIN_OUT_W = 6;
	localparam int TALLY_W   = 20;
	localparam int RDF_W     = 32;
	localparam int ABS_W     = 25;
	localparam int D2_W      = 52;
	localparam int ROOT_W    = D2_W / 2;
	localparam int MDU_W     = 192;
	localparam int MDU_WORDS = MDU_W / 32;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
	localparam logic [31:0] PI_NUM    = 32'd355;
	localparam logic [31:0] RDF_K     = 32'd678;	// six times the pi denominator 113
	localparam logic [31:0] Q16_SCALE = 32'd65536;

	typedef enum logic [1:0] {
		REG_BOX_X = 2'd0,
		REG_BOX_Y = 2'd1,
		REG_BOX_Z = 2'd2,
		REG_BINS  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_MUL   = 3'd1,
		OP_MOVD  = 3'd2,
		OP_ROUND = 3'd3,
		OP_DIV   = 3'd4,
		OP_END   = 3'd5
	} mop_t;

	typedef enum logic [3:0] {
		SEL_NONE    = 4'd0,
		SEL_N       = 4'd1,
		SEL_SHELL   = 4'd2,
		SEL_LMIN    = 4'd3,
		SEL_PI_NUM  = 4'd4,
		SEL_TALLY   = 4'd5,
		SEL_RDF_K   = 4'd6,
		SEL_NB      = 4'd7,
		SEL_LX      = 4'd8,
		SEL_LY      = 4'd9,
		SEL_LZ      = 4'd10,
		SEL_Q16     = 4'd11,
		SEL_FOUR_NB = 4'd12,
		SEL_CTR_NUM = 4'd13,
		SEL_BIN_NUM = 4'd14
	} osel_t;

	typedef enum logic [1:0] {
		PRG_BIN = 2'd0,
		PRG_CTR = 2'd1,
		PRG_RDF = 2'd2
	} prog_t;

	typedef struct packed {
		mop_t  op;
		osel_t sel;
	} uop_t;

	typedef struct packed {
		logic        start;
		mop_t        op;
		logic [31:0] arg;
	} mdu_cmd_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
	} mdu_stat_t;

	// Microcode for the multiply/divide unit. The divisor is built first and moved
	// aside, then the dividend is built and the quotient taken.
	function automatic uop_t prog_op(prog_t prg, logic [4:0] pc);
		uop_t u;
		u = '{op: OP_END, sel: SEL_NONE};
		case (prg)
			PRG_BIN: begin
				case (pc)
					5'd0: u = '{op: OP_LOAD, sel: SEL_LMIN};
					5'd1: u = '{op: OP_MOVD, sel: SEL_NONE};
					5'd2: u = '{op: OP_LOAD, sel: SEL_BIN_NUM};
					5'd3: u = '{op: OP_DIV,  sel: SEL_NONE};
					default: u = '{op: OP_END, sel: SEL_NONE};
				endcase
			end
			PRG_CTR: begin
				case (pc)
					5'd0: u = '{op: OP_LOAD, sel: SEL_FOUR_NB};
					5'd1: u = '{op: OP_MOVD, sel: SEL_NONE};
					5'd2: u = '{op: OP_LOAD, sel: SEL_CTR_NUM};
					5'd3: u = '{op: OP_DIV,  sel: SEL_NONE};
					default: u = '{op: OP_END, sel: SEL_NONE};
				endcase
			end
			PRG_RDF: begin
				case (pc)
					5'd0:  u = '{op: OP_LOAD,  sel: SEL_N};
					5'd1:  u = '{op: OP_MUL,   sel: SEL_N};
					5'd2:  u = '{op: OP_MUL,   sel: SEL_SHELL};
					5'd3:  u = '{op: OP_MUL,   sel: SEL_LMIN};
					5'd4:  u = '{op: OP_MUL,   sel: SEL_LMIN};
					5'd5:  u = '{op: OP_MUL,   sel: SEL_LMIN};
					5'd6:  u = '{op: OP_MUL,   sel: SEL_PI_NUM};
					5'd7:  u = '{op: OP_MOVD,  sel: SEL_NONE};
					5'd8:  u = '{op: OP_LOAD,  sel: SEL_TALLY};
					5'd9:  u = '{op: OP_MUL,   sel: SEL_RDF_K};
					5'd10: u = '{op: OP_MUL,   sel: SEL_NB};
					5'd11: u = '{op: OP_MUL,   sel: SEL_NB};
					5'd12: u = '{op: OP_MUL,   sel: SEL_NB};
					5'd13: u = '{op: OP_MUL,   sel: SEL_LX};
					5'd14: u = '{op: OP_MUL,   sel: SEL_LY};
					5'd15: u = '{op: OP_MUL,   sel: SEL_LZ};
					5'd16: u = '{op: OP_MUL,   sel: SEL_Q16};
					5'd17: u = '{op: OP_ROUND, sel: SEL_NONE};
					5'd18: u = '{op: OP_DIV,   sel: SEL_NONE};
					default: u = '{op: OP_END, sel: SEL_NONE};
				endcase
			end
			default: u = '{op: OP_END, sel: SEL_NONE};
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pdh_isqrt.sv
// Iterative integer square root, one result bit per cycle (restoring method).
// Depends on pdh_pkg for the radicand and root widths.
`default_nettype none
module pdh_isqrt import pdh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [D2_W-1:0]   rad,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);

	localparam int CNT_W = $clog2(ROOT_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [D2_W-1:0]   v_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+1:0] rem_n;
	logic [ROOT_W+1:0] trial;
	logic              take;

	always_comb begin
		rem_n = {rem_q[ROOT_W-1:0], v_q[D2_W-1 -: 2]};
		trial = {root_q, 2'b01};
		take  = (rem_n >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[D2_W-3:0], 2'b00};
			rem_q  <= take ? (rem_n - trial) : rem_n;
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pdh_mdu.sv
// Wide multiply/divide unit: a 192-bit accumulator multiplied word by word by a
// 32-bit factor, and a bit-per-cycle restoring divider with a 32-bit saturating quotient.
// Depends on pdh_pkg for the command and status types.
`default_nettype none
module pdh_mdu import pdh_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire mdu_cmd_t  cmd,
	output mdu_stat_t      stat
);

	logic             busy_q;
	logic             done_q;
	mop_t             op_q;
	logic [4:0]       cnt_q;
	logic [MDU_W-1:0] a_q;
	logic [MDU_W-1:0] d_q;
	logic [MDU_W-1:0] ds_q;
	logic [31:0]      m_q;
	logic [31:0]      carry_q;
	logic [31:0]      q_q;
	logic [63:0]      prod;
	logic             div_sat;
	logic             ge;

	always_comb begin
		prod = 64'(a_q[31:0]) * 64'(m_q) + 64'(carry_q);
		// The quotient overflows 32 bits exactly when the dividend reaches 2^32 divisors.
		div_sat = (d_q[MDU_W-1 -: 32] == '0) && (a_q >= {d_q[MDU_W-33:0], 32'b0});
		ge = (a_q >= ds_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_LOAD;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q  <= cmd.op;
				cnt_q <= '0;
				case (cmd.op)
					OP_MUL: busy_q <= 1'b1;
					OP_DIV: begin
						if (div_sat) done_q <= 1'b1;
						else busy_q <= 1'b1;
					end
					default: done_q <= 1'b1;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if ((op_q == OP_MUL && cnt_q == 5'(MDU_WORDS - 1)) ||
				    (op_q != OP_MUL && cnt_q == 5'd31)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			case (cmd.op)
				OP_LOAD: a_q <= MDU_W'(cmd.arg);
				OP_MOVD: d_q <= a_q;
				OP_ROUND: begin
					a_q <= {a_q[MDU_W-2:0], 1'b0} + d_q;
					d_q <= {d_q[MDU_W-2:0], 1'b0};
				end
				OP_MUL: begin
					m_q     <= cmd.arg;
					carry_q <= '0;
				end
				OP_DIV: begin
					ds_q <= {d_q[MDU_W-32:0], 31'b0};
					q_q  <= div_sat ? '1 : '0;
				end
				default: ;
			endcase
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				a_q     <= {prod[31:0], a_q[MDU_W-1:32]};
				carry_q <= prod[63:32];
			end else begin
				if (ge) a_q <= a_q - ds_q;
				q_q  <= {q_q[30:0], ge};
				ds_q <= {1'b0, ds_q[MDU_W-1:1]};
			end
		end
	end

	assign stat.done = done_q;
	assign stat.quot = q_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pair_distance_histogram_rdf_unit.sv
// Pair-distance histogram and g(r) for particles in a periodic box: position and
// histogram memories, the pair walk sequencer and the result stage.
// Depends on pdh_pkg, pdh_isqrt and pdh_mdu.
//
// Positions load one beat per cycle into a single position memory. On the beat marked
// tlast the block stops taking beats and walks every unordered pair. Pairs beyond the
// cutoff go straight on to the next pair; pairs inside it run the square root and the
// bit-serial divide that picks the bin. Each bin is then reported, most of its work being
// the word-serial multiplies and the divide of the g(r) rational in the shared
// multiply/divide unit. The histogram is cleared by dropping its valid bits after the
// last bin beat, so the next set can load at once.
`default_nettype none
module pair_distance_histogram_rdf_unit import pdh_pkg::*; #(
	parameter int MAX_PARTICLES = 1024,
	parameter int MAX_BINS      = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [23:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,	// pos_x, pos_y, pos_z
	input  wire logic        s_tlast,	// final_particle
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,	// bin_number, bin_center, pair_tally, rdf_value, pad
	output logic             m_tlast	// final_bin
);

	localparam int PA_W   = $clog2(MAX_PARTICLES);
	localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
	localparam int BIN_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

	typedef enum logic [16:0] {
		ST_IDLE  = 17'h00001,
		ST_SETUP = 17'h00002,
		ST_PI    = 17'h00004,
		ST_PIW   = 17'h00008,
		ST_RDJ   = 17'h00010,
		ST_PJ    = 17'h00020,
		ST_SQ    = 17'h00040,
		ST_CUT   = 17'h00080,
		ST_SQRT  = 17'h00100,
		ST_MISS  = 17'h00200,
		ST_MWAIT = 17'h00400,
		ST_HRD   = 17'h00800,
		ST_HWR   = 17'h01000,
		ST_NEXT  = 17'h02000,
		ST_ERD   = 17'h04000,
		ST_ELAT  = 17'h08000,
		ST_OUT   = 17'h10000
	} state_t;

	state_t state_q;

	logic [COORD_W-1:0] box_x_q, box_y_q, box_z_q;
	logic [NB_W-1:0]    bins_q;
	logic [COORD_W-1:0] lx_q, ly_q, lz_q, lmin_q;
	logic [NB_W-1:0]    nb_q;
	logic [47:0]        lmin2_q;
	logic [CNT_W-1:0]   count_q, i_q, j_q;
	logic [71:0]        pi_q;
	logic [ABS_W-1:0]   ab_q [3];
	logic [1:0]         k_q;
	logic [49:0]        sq_s2;
	logic [D2_W-1:0]    d2_q;
	logic [ROOT_W-1:0]  s_q;
	prog_t              prog_q;
	logic [4:0]         pc_q;
	logic [NB_W-1:0]    bin_q, b_q;
	logic [TALLY_W-1:0] tally_q;
	logic [COORD_W-1:0] center_q;
	logic [RDF_W-1:0]   rdf_q;
	logic [MAX_BINS-1:0] hv_q;

	logic [71:0]        pos_mem [MAX_PARTICLES];
	logic [71:0]        prd_q;
	logic [TALLY_W-1:0] hist_mem [MAX_BINS];
	logic [TALLY_W-1:0] hrd_q;

	logic               in_acc;
	logic [CNT_W-1:0]   prd_addr;
	logic [BIN_AW-1:0]  hrd_addr;
	logic [COORD_W-1:0] lx_e, ly_e, lz_e, lmin_e;
	logic [NB_W-1:0]    nb_e;
	uop_t               uop;
	logic [31:0]        opnd;
	logic [31:0]        b32;
	logic [TALLY_W:0]   hsum;
	logic [TALLY_W-1:0] hold;
	logic               sq_start, sq_done;
	logic [ROOT_W-1:0]  sq_root;
	mdu_cmd_t           mcmd;
	mdu_stat_t          mstat;

	function automatic logic [ABS_W-1:0] wrap_abs(logic [COORD_W-1:0] a,
			logic [COORD_W-1:0] b, logic [COORD_W-1:0] len);
		logic signed [26:0] d;
		logic signed [26:0] l;
		d = $signed({3'b000, a}) - $signed({3'b000, b});
		l = $signed({3'b000, len});
		if ((d <<< 1) > l) d = d - l;
		if ((d <<< 1) < -l) d = d + l;
		return d[26] ? ABS_W'(-d) : ABS_W'(d);
	endfunction

	pdh_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (d2_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	pdh_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mcmd),
		.stat   (mstat)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tlast  = (b_q == nb_q - 1'b1);
	assign m_tdata  = {6'b0, rdf_q, tally_q, center_q, BIN_OUT_W'(b_q)};

	always_comb begin
		lx_e = (box_x_q == '0) ? COORD_W'(1) : box_x_q;
		ly_e = (box_y_q == '0) ? COORD_W'(1) : box_y_q;
		lz_e = (box_z_q == '0) ? COORD_W'(1) : box_z_q;
		lmin_e = lx_e;
		if (ly_e < lmin_e) lmin_e = ly_e;
		if (lz_e < lmin_e) lmin_e = lz_e;
		nb_e = (bins_q == '0) ? NB_W'(1) : bins_q;
		if (32'(nb_e) > MAX_BINS) nb_e = NB_W'(MAX_BINS);
	end

	always_comb begin
		uop = prog_op(prog_q, pc_q);
		b32 = 32'(b_q);
		unique case (uop.sel)
			SEL_N:       opnd = 32'(count_q);
			SEL_SHELL:   opnd = 32'd3 * b32 * b32 + 32'd3 * b32 + 32'd1;
			SEL_LMIN:    opnd = 32'(lmin_q);
			SEL_PI_NUM:  opnd = PI_NUM;
			SEL_TALLY:   opnd = 32'(tally_q);
			SEL_RDF_K:   opnd = RDF_K;
			SEL_NB:      opnd = 32'(nb_q);
			SEL_LX:      opnd = 32'(lx_q);
			SEL_LY:      opnd = 32'(ly_q);
			SEL_LZ:      opnd = 32'(lz_q);
			SEL_Q16:     opnd = Q16_SCALE;
			SEL_FOUR_NB: opnd = 32'({nb_q, 2'b00});
			SEL_CTR_NUM: opnd = 32'(lmin_q) * 32'({b_q, 1'b1}) + 32'({nb_q, 1'b0});
			SEL_BIN_NUM: opnd = 32'(s_q) * 32'({nb_q, 1'b0});
			default:     opnd = '0;
		endcase
		mcmd.start = (state_q == ST_MISS) && (uop.op != OP_END);
		mcmd.op    = uop.op;
		mcmd.arg   = opnd;
	end

	always_comb begin
		prd_addr = (state_q == ST_PI) ? i_q : j_q;
		hrd_addr = (state_q == ST_ERD) ? BIN_AW'(b_q) : BIN_AW'(bin_q);
		hold     = hv_q[BIN_AW'(bin_q)] ? hrd_q : '0;
		hsum     = {1'b0, hold} + (TALLY_W + 1)'(2);
		sq_start = (state_q == ST_CUT) && ({d2_q, 2'b00} < (D2_W + 2)'(lmin2_q));
	end

	// Memories: registered reads, one write port each.
	always_ff @(posedge clk) begin
		if (in_acc && count_q < CNT_W'(MAX_PARTICLES)) begin
			pos_mem[count_q[PA_W-1:0]] <= s_tdata;
		end
		prd_q <= pos_mem[prd_addr[PA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HWR) begin
			hist_mem[BIN_AW'(bin_q)] <= hsum[TALLY_W] ? TALLY_MAX : hsum[TALLY_W-1:0];
		end
		hrd_q <= hist_mem[hrd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= COORD_W'(2560);
			box_y_q <= COORD_W'(2560);
			box_z_q <= COORD_W'(2560);
			bins_q  <= NB_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BOX_X: box_x_q <= cfg_wdata;
				REG_BOX_Y: box_y_q <= cfg_wdata;
				REG_BOX_Z: box_z_q <= cfg_wdata;
				REG_BINS:  bins_q  <= cfg_wdata[NB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			prog_q  <= PRG_BIN;
			pc_q    <= '0;
			b_q     <= '0;
			nb_q    <= NB_W'(1);
			hv_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (count_q < CNT_W'(MAX_PARTICLES)) count_q <= count_q + 1'b1;
						if (s_tlast) begin
							nb_q    <= nb_e;
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					i_q <= '0;
					j_q <= CNT_W'(1);
					b_q <= '0;
					state_q <= (count_q < CNT_W'(2)) ? ST_ERD : ST_PI;
				end
				ST_PI:  state_q <= ST_PIW;
				ST_PIW: state_q <= ST_RDJ;
				ST_RDJ: state_q <= ST_PJ;
				ST_PJ: begin
					k_q     <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) state_q <= ST_CUT;
				end
				ST_CUT: state_q <= sq_start ? ST_SQRT : ST_NEXT;
				ST_SQRT: begin
					if (sq_done) begin
						prog_q  <= PRG_BIN;
						pc_q    <= '0;
						state_q <= ST_MISS;
					end
				end
				ST_MISS: begin
					if (uop.op != OP_END) begin
						state_q <= ST_MWAIT;
					end else begin
						unique case (prog_q)
							PRG_BIN: state_q <= ST_HRD;
							PRG_CTR: begin
								if (count_q < CNT_W'(2)) begin
									state_q <= ST_OUT;
								end else begin
									prog_q  <= PRG_RDF;
									pc_q    <= '0;
									state_q <= ST_MISS;
								end
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_MWAIT: begin
					if (mstat.done) begin
						pc_q    <= pc_q + 1'b1;
						state_q <= ST_MISS;
					end
				end
				ST_HRD: state_q <= ST_HWR;
				ST_HWR: begin
					hv_q[BIN_AW'(bin_q)] <= 1'b1;
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (j_q + 1'b1 < count_q) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_RDJ;
					end else if (i_q + CNT_W'(2) < count_q) begin
						i_q     <= i_q + 1'b1;
						j_q     <= i_q + CNT_W'(2);
						state_q <= ST_PI;
					end else begin
						b_q     <= '0;
						state_q <= ST_ERD;
					end
				end
				ST_ERD: state_q <= ST_ELAT;
				ST_ELAT: begin
					prog_q  <= PRG_CTR;
					pc_q    <= '0;
					state_q <= ST_MISS;
				end
				ST_OUT: begin
					if (m_tready) begin
						if (m_tlast) begin
							count_q <= '0;
							hv_q    <= '0;
							state_q <= ST_IDLE;
						end else begin
							b_q     <= b_q + 1'b1;
							state_q <= ST_ERD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && s_tlast) begin
			lx_q   <= lx_e;
			ly_q   <= ly_e;
			lz_q   <= lz_e;
			lmin_q <= lmin_e;
		end
		if (state_q == ST_SETUP) lmin2_q <= 48'(lmin_q) * 48'(lmin_q);
		if (state_q == ST_PIW) pi_q <= prd_q;
		if (state_q == ST_PJ) begin
			ab_q[0] <= wrap_abs(pi_q[23:0],  prd_q[23:0],  lx_q);
			ab_q[1] <= wrap_abs(pi_q[47:24], prd_q[47:24], ly_q);
			ab_q[2] <= wrap_abs(pi_q[71:48], prd_q[71:48], lz_q);
		end
		if (state_q == ST_SQ) begin
			if (k_q != 2'd3) sq_s2 <= 50'(ab_q[k_q]) * 50'(ab_q[k_q]);
			d2_q <= (k_q == 2'd0) ? '0 : d2_q + D2_W'(sq_s2);
		end
		if (state_q == ST_SQRT && sq_done) s_q <= sq_root;
		if (state_q == ST_MISS && uop.op == OP_END) begin
			unique case (prog_q)
				PRG_BIN: bin_q <= (mstat.quot >= 32'(nb_q)) ? nb_q - 1'b1
				                                           : mstat.quot[NB_W-1:0];
				PRG_CTR: begin
					center_q <= mstat.quot[COORD_W-1:0];
					if (count_q < CNT_W'(2)) rdf_q <= '0;
				end
				default: rdf_q <= mstat.quot;
			endcase
		end
		if (state_q == ST_ELAT) tally_q <= hv_q[BIN_AW'(b_q)] ? hrd_q : '0;
	end

`ifndef SYNTHESIS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output sides active together");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PARTICLES))
		else $error("particle count beyond capacity");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RDJ |-> (j_q > i_q && j_q < count_q))
		else $error("pair walk index out of order");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HRD |-> bin_q < nb_q)
		else $error("histogram bin out of range");

	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (count_q == '0 && hv_q == '0))
		else $error("state not cleared after last bin");
`endif

endmodule
`default_nettype wire

FILE: sim/pair_distance_histogram_rdf_unit_tb.sv
// Testbench for pair_distance_histogram_rdf_unit: streams particle sets, predicts each bin beat
// (center, pair tally, g(r)) and checks it field by field. Depends on pdh_pkg and the block RTL.
`timescale 1ns / 1ps
module pair_distance_histogram_rdf_unit_tb;
	import pdh_pkg::*;

	localparam int NPART = 1024;
	localparam int NBINS = 64;
	localparam longint CYCLE_LIMIT = 60_000_000;

	typedef struct {
		logic [BIN_OUT_W-1:0] bin;
		logic [COORD_W-1:0]   center;
		logic [TALLY_W-1:0]   tally;
		logic [RDF_W-1:0]     rdf;
		logic                 last;
	} bin_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [23:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic m_tlast;

	pair_distance_histogram_rdf_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the block state.
	logic [COORD_W-1:0] px [NPART];
	logic [COORD_W-1:0] py [NPART];
	logic [COORD_W-1:0] pz [NPART];
	logic [TALLY_W-1:0] hist [NBINS];
	int unsigned loaded;
	logic [23:0] box_x = 24'd2560, box_y = 24'd2560, box_z = 24'd2560;
	logic [6:0] bins_cfg = 7'd64;

	bin_report_t pending_bins[$];
	int errors = 0;
	int beats_in = 0, beats_out = 0, sets_done = 0;
	int idle_pct = 0, stall_pct = 0;
	int hold_cycles = 0;
	longint cycles = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0h expected %0h (bin beat %0d)", what, got, want, beats_out);
		errors++;
	endtask

	function automatic longint unsigned min_image_abs(logic [23:0] a, logic [23:0] b,
			longint unsigned side);
		longint d;
		longint l;
		d = longint'(a) - longint'(b);
		l = longint'(side);
		if (2 * d > l) d -= l;
		if (2 * d < -l) d += l;
		return (d < 0) ? -d : d;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int k = 26; k >= 0; k--) begin
			t = r | (64'd1 << k);
			if (t * t <= v) r = t;
		end
		return r;
	endfunction

	function automatic logic [31:0] rdf_ratio(longint unsigned tally, longint unsigned n,
			longint unsigned nb, longint unsigned b, longint unsigned lx,
			longint unsigned ly, longint unsigned lz, longint unsigned lmin);
		logic [191:0] num;
		logic [191:0] den;
		logic [191:0] q;
		if (n < 2) return '0;
		num = 192'(tally) * 678 * nb * nb * nb;
		num = num * lx * ly * lz * 65536;
		den = 192'(n) * n * (3 * b * b + 3 * b + 1);
		den = den * lmin * lmin * lmin * 355;
		q = (2 * num + den) / (2 * den);
		return (q > 192'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	// Accounts for one accepted position beat; a final beat runs the pair walk.
	task automatic absorb_position(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic fin);
		longint unsigned lx, ly, lz, lmin, nb, d2, bin;
		bin_report_t r;
		if (loaded < NPART) begin
			px[loaded] = x;
			py[loaded] = y;
			pz[loaded] = z;
			loaded++;
		end
		if (!fin) return;
		lx = (box_x == 0) ? 1 : box_x;
		ly = (box_y == 0) ? 1 : box_y;
		lz = (box_z == 0) ? 1 : box_z;
		lmin = lx;
		if (ly < lmin) lmin = ly;
		if (lz < lmin) lmin = lz;
		nb = (bins_cfg == 0) ? 1 : (bins_cfg > NBINS) ? NBINS : bins_cfg;
		for (int i = 0; i + 1 < loaded; i++)
			for (int j = i + 1; j < loaded; j++) begin
				d2 = min_image_abs(px[i], px[j], lx) ** 2 + min_image_abs(py[i], py[j], ly) ** 2
				   + min_image_abs(pz[i], pz[j], lz) ** 2;
				if (4 * d2 < lmin * lmin) begin
					bin = (2 * nb * int_sqrt(d2)) / lmin;
					if (bin >= nb) bin = nb - 1;
					hist[bin] = (hist[bin] > TALLY_MAX - 2) ? TALLY_MAX
					          : TALLY_W'(hist[bin] + 2);
				end
			end
		for (int b = 0; b < nb; b++) begin
			r.bin = b[5:0];
			r.center = 24'((lmin * (2 * b + 1) + 2 * nb) / (4 * nb));
			r.tally = hist[b];
			r.rdf = rdf_ratio(hist[b], loaded, nb, b, lx, ly, lz, lmin);
			r.last = (b == nb - 1);
			pending_bins.push_back(r);
			hist[b] = '0;
		end
		loaded = 0;
		sets_done++;
	endtask

	task automatic send_position(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic fin);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		absorb_position(x, y, z, fin);
		beats_in++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		wait (pending_bins.size() == 0);
		repeat (64) @(negedge clk);
	endtask

	// Leaves the write enable high; the caller drops it after its last write.
	task automatic write_reg(reg_idx_t idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		case (idx)
			REG_BOX_X: box_x = val;
			REG_BOX_Y: box_y = val;
			REG_BOX_Z: box_z = val;
			REG_BINS:  bins_cfg = val[6:0];
		endcase
	endtask

	task automatic set_box(logic [23:0] lx, logic [23:0] ly, logic [23:0] lz, logic [6:0] nb);
		drain();
		write_reg(REG_BOX_X, lx);
		write_reg(REG_BOX_Y, ly);
		write_reg(REG_BOX_Z, lz);
		write_reg(REG_BINS, {17'd0, nb});
		cfg_we <= 1'b0;
	endtask

	// Output side: random stalls plus an optional long hold-off.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d bin beats outstanding", pending_bins.size());
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			bin_report_t e;
			beats_out++;
			if (pending_bins.size() == 0) begin
				report("unexpected bin beat", longint'(m_tdata[5:0]), 0);
			end else begin
				e = pending_bins.pop_front();
				if (m_tdata[5:0] != e.bin) report("bin_number", m_tdata[5:0], e.bin);
				if (m_tdata[29:6] != e.center) report("bin_center", m_tdata[29:6], e.center);
				if (m_tdata[49:30] != e.tally) report("pair_tally", m_tdata[49:30], e.tally);
				if (m_tdata[81:50] != e.rdf) report("rdf_value", m_tdata[81:50], e.rdf);
				if (m_tlast != e.last) report("final_bin", m_tlast, e.last);
			end
		end
	end

	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		// A lone particle gives zero tallies and zero g(r).
		send_position(24'd100, 24'd200, 24'd300, 1'b1);
		// Coincident pair lands in bin zero; opposite extremes exercise the wrap.
		send_position(24'd0, 24'd0, 24'd0, 1'b0);
		send_position(24'd0, 24'd0, 24'd0, 1'b0);
		send_position(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
		send_position(24'd2559, 24'd1, 24'd1280, 1'b1);
		// Zero bins act as one, oversize bins as the maximum.
		set_box(24'd1000, 24'd3000, 24'd2000, 7'd0);
		send_position(24'd10, 24'd20, 24'd30, 1'b0);
		send_position(24'd990, 24'd2990, 24'd1990, 1'b1);
		set_box(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 7'd127);
		send_position(24'hFFFFFF, 24'd0, 24'h800000, 1'b0);
		send_position(24'd0, 24'hFFFFFF, 24'h7FFFFF, 1'b0);
		send_position(24'h123456, 24'hABCDEF, 24'h555555, 1'b1);
		// A zero side is taken as one.
		set_box(24'd0, 24'd1, 24'd512, 7'd1);
		send_position(24'd0, 24'd0, 24'd0, 1'b0);
		send_position(24'd0, 24'd0, 24'd7, 1'b1);
		set_box(24'd2560, 24'd2560, 24'd2560, 7'd64);
		send_position(24'd1280, 24'd1280, 24'd1280, 1'b0);
		send_position(24'd1281, 24'd1279, 24'd1280, 1'b0);
		send_position(24'd0, 24'd2559, 24'd640, 1'b1);
		drain();
	endtask

	task automatic send_random_set(int unsigned count, logic [23:0] span);
		logic noise;
		for (int i = 0; i < count; i++) begin
			noise = ($urandom_range(15) == 0);
			send_position(noise ? 24'($urandom) : 24'($urandom_range(span)),
				noise ? 24'($urandom) : 24'($urandom_range(span)),
				noise ? 24'($urandom) : 24'($urandom_range(span)), i == count - 1);
		end
	endtask

	task automatic test_random(int unsigned items, int idle, int stall);
		int unsigned sent;
		int unsigned count;
		logic [23:0] side;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(2) == 0) begin
				side = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(20000, 64));
				set_box(side, side + 24'($urandom_range(800)), side + 24'($urandom_range(800)),
					($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(16, 1)));
			end
			count = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(10, 1);
			send_random_set(count, box_x);
			sent += count;
		end
		drain();
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		set_box(24'd3000, 24'd3000, 24'd3000, 7'd8);
		hold_cycles = 4000;
		send_random_set(6, 24'd3000);
		send_random_set(5, 24'd3000);
		send_random_set(4, 24'd3000);
		drain();
	endtask

	initial begin
		for (int b = 0; b < NBINS; b++) hist[b] = '0;
		loaded = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(100, 0, 0);
		test_random(100, 76, 0);
		test_random(100, 0, 76);
		test_random(100, 27, 27);
		test_backpressure();
		repeat (200) @(negedge clk);
		$display("Streamed %0d position beats in %0d sets and checked %0d bin beats.",
			beats_in, sets_done, beats_out);
		$display("Covered extreme and wrapped coordinates, bin clamping, zero sides and a long "
			, "output hold-off.");
		if (errors == 0 && pending_bins.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
